@@ hw/rtl/spmv_pkg.sv @@
// Shared types and constants for the CSR sparse matrix vector multiply block.
package spmv_pkg;

  // Vector store depth and the address width that follows from it.
  localparam int VECTOR_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VECTOR_DEPTH);

  // Depth of the work queue between the front and back parts.
  localparam int QUEUE_DEPTH  = 4;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_LOAD      = 2'd0;
  localparam logic [1:0] ACT_NONZERO   = 2'd1;
  localparam logic [1:0] ACT_EMPTY_ROW = 2'd2;

  // Saturation limits of the Q32.32 accumulator.
  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  // One input beat.
  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         index;
    logic signed [31:0] value;
    logic               row_end;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [15:0]        row_number;
    logic signed [63:0] row_sum;
  } out_item_t;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic signed [31:0] xval;
    logic               last;
  } work_t;

endpackage

@@ hw/rtl/spmv_front.sv @@
// Front part: accepts input beats, owns the vector store and classifies work.
module spmv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  spmv_pkg::in_item_t item,
  output logic              q_push,
  output spmv_pkg::work_t   q_data,
  input  logic              q_full
);

  logic [31:0] mem [spmv_pkg::VECTOR_DEPTH];
  logic [31:0] rd_data;

  logic [spmv_pkg::ADDR_W-1:0] addr;
  logic                        in_range;
  logic                        accept;
  logic                        useful;

  logic              s_valid;
  logic [1:0]        s_op;
  logic signed [31:0] s_value;
  logic              s_last;
  logic              s_in_range;

  // The stage holds its beat while the queue is full, so the input stalls then.
  assign full     = s_valid && q_full;
  assign accept   = push && !full;
  assign addr     = spmv_pkg::ADDR_W'(item.index);
  assign in_range = (32'(item.index) < 32'(spmv_pkg::VECTOR_DEPTH));
  assign useful   = (item.action == spmv_pkg::ACT_LOAD) ||
                    (item.action == spmv_pkg::ACT_NONZERO) ||
                    (item.action == spmv_pkg::ACT_EMPTY_ROW);

  // Vector store: written by loads, read for every accepted beat.
  always_ff @(posedge clk) begin
    if (accept && item.action == spmv_pkg::ACT_LOAD && in_range) begin
      mem[addr] <= item.value;
    end
    if (accept) begin
      rd_data <= mem[addr];
    end
  end

  // Classification stage; the unused action code is dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= useful;
    end else if (q_push) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_op       <= item.action;
      s_value    <= item.value;
      s_last     <= item.row_end;
      s_in_range <= in_range;
    end
  end

  // Hand the work to the queue; an entry beyond the store reads as zero.
  assign q_push       = s_valid && !q_full;
  assign q_data.op    = s_op;
  assign q_data.value = s_value;
  assign q_data.xval  = s_in_range ? rd_data : 32'sd0;
  assign q_data.last  = s_last;

endmodule

@@ hw/rtl/spmv_queue.sv @@
// Short work queue between the front and back parts.
module spmv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  spmv_pkg::work_t wdata,
  output logic            full,
  input  logic            pop,
  output spmv_pkg::work_t rdata,
  output logic            empty
);

  localparam int PTR_W = $clog2(spmv_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(spmv_pkg::QUEUE_DEPTH + 1);

  spmv_pkg::work_t slots [spmv_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(spmv_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(spmv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(spmv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // An empty or full queue has its pointers together.
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with the fill count");

endmodule

@@ hw/rtl/spmv_back.sv @@
// Back part: multiplies, accumulates with saturation and buffers row results.
module spmv_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  spmv_pkg::work_t     q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output spmv_pkg::out_item_t result
);

  // Multiply stage.
  logic               m_valid;
  logic [1:0]         m_op;
  logic               m_last;
  logic signed [63:0] m_prod;

  // Row state.
  logic signed [63:0] acc;
  logic [15:0]        row_cnt;

  // Two-entry result buffer.
  spmv_pkg::out_item_t ob [2];
  logic [1:0]          out_count;

  logic               emits;
  logic               acc_fire;
  logic               out_pop;
  logic signed [63:0] sum;
  logic signed [63:0] acc_sat;
  spmv_pkg::out_item_t new_result;

  assign emits    = (m_op == spmv_pkg::ACT_EMPTY_ROW) ||
                    (m_op == spmv_pkg::ACT_NONZERO && m_last);
  assign acc_fire = m_valid && (!emits || out_count != 2'd2);
  assign q_pop    = !q_empty && (!m_valid || acc_fire);
  assign out_pop  = pop && !empty;

  // Multiply stage takes a new beat whenever it is empty or the accumulate step moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (!m_valid || acc_fire) begin
      m_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_op   <= q_data.op;
      m_last <= q_data.last;
      m_prod <= q_data.value * q_data.xval;
    end
  end

  // Saturating add of the product into the accumulator.
  always_comb begin
    sum = acc + m_prod;
    if (!acc[63] && !m_prod[63] && sum[63]) begin
      acc_sat = spmv_pkg::SUM_MAX;
    end else if (acc[63] && m_prod[63] && !sum[63]) begin
      acc_sat = spmv_pkg::SUM_MIN;
    end else begin
      acc_sat = sum;
    end
  end

  assign new_result.row_number = row_cnt;
  assign new_result.row_sum    = (m_op == spmv_pkg::ACT_NONZERO) ? acc_sat : acc;

  // Accumulator and row counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      row_cnt <= '0;
    end else if (acc_fire) begin
      case (m_op)
        spmv_pkg::ACT_LOAD: begin
          acc     <= '0;
          row_cnt <= '0;
        end
        spmv_pkg::ACT_NONZERO: begin
          if (m_last) begin
            acc     <= '0;
            row_cnt <= row_cnt + 16'd1;
          end else begin
            acc <= acc_sat;
          end
        end
        spmv_pkg::ACT_EMPTY_ROW: begin
          acc     <= '0;
          row_cnt <= row_cnt + 16'd1;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // Result buffer occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= '0;
    end else if (acc_fire && emits && !out_pop) begin
      out_count <= out_count + 2'd1;
    end else if (out_pop && !(acc_fire && emits)) begin
      out_count <= out_count - 2'd1;
    end
  end

  // Result buffer entries; a simultaneous push and pop only happens with one entry held.
  always_ff @(posedge clk) begin
    if (acc_fire && emits && out_pop) begin
      ob[0] <= new_result;
    end else if (acc_fire && emits) begin
      ob[out_count[0]] <= new_result;
    end else if (out_pop) begin
      ob[0] <= ob[1];
    end
  end

  assign empty  = (out_count == 2'd0);
  assign result = ob[0];

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3)
    else $error("result buffer overfilled");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    acc_fire && m_op == spmv_pkg::ACT_LOAD |=> acc == '0 && row_cnt == '0)
    else $error("vector load did not restart the rows");

  a_row_advance: assert property (@(posedge clk) disable iff (rst)
    acc_fire && emits |=> row_cnt == $past(row_cnt) + 16'd1 && acc == '0)
    else $error("row close did not advance the row counter");

endmodule

@@ hw/rtl/csr_sparse_matrix_vector_multiply.sv @@
// A row result passes the front stage, work queue, multiply stage and result buffer.
// Throughput: one input beat per cycle, set by the single 32x32 multiplier and the
// 64-bit saturating accumulator; the input stalls while the work queue is full.
// Reset: rst clears the accumulator, row counter, queues and pipeline valids;
// the vector store is not cleared and holds no data until loaded.
module csr_sparse_matrix_vector_multiply (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  spmv_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output spmv_pkg::out_item_t result
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  spmv_pkg::work_t q_wdata;
  spmv_pkg::work_t q_rdata;

  // Front part: vector store and classification.
  spmv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // Work queue between the parts.
  spmv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back part: multiply, accumulate and result buffer.
  spmv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
